// File: sv/kruskal_quick_find_merger_core_macros.svh
// assertion macros used by the merger core top level
`ifndef KRUSKAL_QUICK_FIND_MERGER_CORE_MACROS_SVH
`define KRUSKAL_QUICK_FIND_MERGER_CORE_MACROS_SVH

// same-cycle implication, clocked on clock, off while reset is high
`define KQF_CHECK_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kqf check failed");

// next-cycle implication, clocked on clock, off while reset is high
`define KQF_CHECK_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kqf check failed");

`endif

// File: sv/kqf_pkg.sv
// shared widths, request codes and control struct of the merger core
package kqf_pkg;

   localparam int FUNC_W   = 2;
   localparam int NODE_W   = 10;
   localparam int WEIGHT_W = 24;
   localparam int TOTAL_W  = 34;
   localparam int NV_W     = 11;

   localparam logic [NV_W-1:0] NV_RESET = 11'd1024;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LINK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd2;

   // labels per reduction group in the cell row
   localparam int GROUP_SIZE = 32;

   // control handed from the sequencer to the label row
   typedef struct packed {
      logic load;     // capture the endpoint labels
      logic clear;    // every cell back to its own index
      logic relabel;  // rewrite both old labels to the kept one
   } kqf_cmd_type;

endpackage

// File: sv/kqf_label_cell.sv
// one component label cell with lookup chain taps and relabel logic
module kqf_label_cell #(
   parameter int LW  = 10,
   parameter int IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [kqf_pkg::NODE_W-1:0]   node_a,
   input  logic [kqf_pkg::NODE_W-1:0]   node_b,
   input  kqf_pkg::kqf_cmd_type         cmd,
   input  logic [LW-1:0]                old_a,
   input  logic [LW-1:0]                old_b,
   input  logic [LW-1:0]                keep,
   input  logic [LW-1:0]                chain_a_in,
   input  logic [LW-1:0]                chain_b_in,
   output logic [LW-1:0]                chain_a_out,
   output logic [LW-1:0]                chain_b_out
);
   import kqf_pkg::*;

   // cells past the node index range are never addressed
   localparam bit REACH = (IDX < (1 << NODE_W));
   localparam logic [LW-1:0] OWN = LW'(IDX);

   logic [LW-1:0] label_ff;
   logic [LW-1:0] label_in;
   logic          hit_a;
   logic          hit_b;

   assign hit_a = REACH && (node_a == NODE_W'(IDX));
   assign hit_b = REACH && (node_b == NODE_W'(IDX));

   assign chain_a_out = chain_a_in | (hit_a ? label_ff : '0);
   assign chain_b_out = chain_b_in | (hit_b ? label_ff : '0);

   always_comb begin
      label_in = label_ff;
      if (cmd.clear) begin
         label_in = OWN;
      end else if (cmd.relabel && (label_ff == old_a || label_ff == old_b)) begin
         label_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= OWN;
      end else begin
         label_ff <= label_in;
      end
   end

endmodule

// File: sv/kqf_label_row.sv
// row of label cells with grouped lookup chains and registered reduction
module kqf_label_row #(
   parameter int MAX_VERTICES = 1024,
   parameter int LW           = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [kqf_pkg::NODE_W-1:0]   node_a,
   input  logic [kqf_pkg::NODE_W-1:0]   node_b,
   input  kqf_pkg::kqf_cmd_type         cmd,
   input  logic [LW-1:0]                keep,
   output logic [LW-1:0]                label_a_ff,
   output logic [LW-1:0]                label_b_ff
);
   import kqf_pkg::*;

   localparam int NGRP = (MAX_VERTICES + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [LW-1:0] chain_a [MAX_VERTICES];
   logic [LW-1:0] chain_b [MAX_VERTICES];
   logic [LW-1:0] grp_a_ff [NGRP];
   logic [LW-1:0] grp_b_ff [NGRP];
   logic [LW-1:0] label_a_in;
   logic [LW-1:0] label_b_in;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      logic [LW-1:0] in_a;
      logic [LW-1:0] in_b;
      if ((i % GROUP_SIZE) == 0) begin : g_head
         assign in_a = '0;
         assign in_b = '0;
      end else begin : g_link
         assign in_a = chain_a[i-1];
         assign in_b = chain_b[i-1];
      end
      kqf_label_cell #(
         .LW  (LW),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .node_a      (node_a),
         .node_b      (node_b),
         .cmd         (cmd),
         .old_a       (label_a_ff),
         .old_b       (label_b_ff),
         .keep        (keep),
         .chain_a_in  (in_a),
         .chain_b_in  (in_b),
         .chain_a_out (chain_a[i]),
         .chain_b_out (chain_b[i])
      );
   end

   // group partials follow the request ports every cycle
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      localparam int TAIL = ((g + 1) * GROUP_SIZE < MAX_VERTICES) ?
                            (g + 1) * GROUP_SIZE - 1 : MAX_VERTICES - 1;
      always_ff @(posedge clock) begin
         grp_a_ff[g] <= chain_a[TAIL];
         grp_b_ff[g] <= chain_b[TAIL];
      end
   end

   always_comb begin
      label_a_in = '0;
      label_b_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         label_a_in = label_a_in | grp_a_ff[g];
         label_b_in = label_b_in | grp_b_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         label_a_ff <= label_a_in;
         label_b_ff <= label_b_in;
      end
   end

endmodule

// File: sv/kruskal_quick_find_merger_core.sv
// top level of the quick-find kruskal merger: sequencer, total and channels
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | func, node_a, node_b, weight
//  rsp_    | out       | rsp_valid/rsp_stall  | joined, total_length
//  csr_    | in        | csr_valid/csr_ready  | num_vertices
//
// each request runs a lookup into the group registers on accept, a reduction of
// the groups into the endpoint labels, then the merge broadcast to every cell
// reset clears labels to their own index, the total to zero and num_vertices to
// 1024, with no clearing pass
// a stalled response holds the merge step, and no new request is taken meanwhile
`include "kruskal_quick_find_merger_core_macros.svh"
module kruskal_quick_find_merger_core #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [kqf_pkg::FUNC_W-1:0]     req_func,
   input  logic [kqf_pkg::NODE_W-1:0]     req_node_a,
   input  logic [kqf_pkg::NODE_W-1:0]     req_node_b,
   input  logic [kqf_pkg::WEIGHT_W-1:0]   req_weight,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_joined,
   output logic [kqf_pkg::TOTAL_W-1:0]    rsp_total_length,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kqf_pkg::NV_W-1:0]       csr_num_vertices
);
   import kqf_pkg::*;

   localparam int LW = $clog2(MAX_VERTICES);

   // one-hot sequencer
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_REDUCE = 3'b010,
      ST_MERGE  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [NODE_W-1:0]     node_a_ff;
   logic [NODE_W-1:0]     node_b_ff;
   logic [WEIGHT_W-1:0]   weight_ff;
   logic [NV_W-1:0]       num_vertices_ff;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_joined_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   logic                  req_take;
   logic                  fire;
   logic                  a_ok;
   logic                  b_ok;
   logic                  is_merge;
   logic                  join_now;
   logic [LW-1:0]         label_a;
   logic [LW-1:0]         label_b;
   logic [LW-1:0]         keep;
   logic [TOTAL_W:0]      sum;
   kqf_cmd_type           cmd;

   // channel handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // merge step completes once the response register is free
   assign fire = (state_ff == ST_MERGE) && (!rsp_valid_ff || !rsp_stall);

   // endpoint range check against min(num_vertices, MAX_VERTICES)
   assign a_ok = ({1'b0, node_a_ff} < num_vertices_ff) && (32'(node_a_ff) < MAX_VERTICES);
   assign b_ok = ({1'b0, node_b_ff} < num_vertices_ff) && (32'(node_b_ff) < MAX_VERTICES);
   assign is_merge = (func_ff == FUNC_LINK) || (func_ff == FUNC_EDGE);
   assign join_now = is_merge && a_ok && b_ok && (label_a != label_b);
   assign keep     = (label_a < label_b) ? label_a : label_b;

   // command to the cells
   assign cmd.load    = (state_ff == ST_REDUCE);
   assign cmd.clear   = fire && (func_ff == FUNC_CLEAR);
   assign cmd.relabel = fire && join_now;

   // label cells: lookup is driven straight from the request ports
   kqf_label_row #(
      .MAX_VERTICES (MAX_VERTICES),
      .LW           (LW)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .node_a     (req_node_a),
      .node_b     (req_node_b),
      .cmd        (cmd),
      .keep       (keep),
      .label_a_ff (label_a),
      .label_b_ff (label_b)
   );

   // saturating total
   assign sum = {1'b0, total_ff} + {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, weight_ff};

   always_comb begin
      total_in = total_ff;
      if (cmd.clear) begin
         total_in = '0;
      end else if (fire && join_now && (func_ff == FUNC_EDGE)) begin
         total_in = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         total_ff        <= '0;
         num_vertices_ff <= NV_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         if (csr_valid && csr_ready) begin
            num_vertices_ff <= csr_num_vertices;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff   <= req_func;
         node_a_ff <= req_node_a;
         node_b_ff <= req_node_b;
         weight_ff <= req_weight;
      end
      if (fire) begin
         rsp_joined_ff <= join_now;
         rsp_total_ff  <= total_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_joined       = rsp_joined_ff;
   assign rsp_total_length = rsp_total_ff;

   // an accepted request always moves on to the reduction step
   `KQF_CHECK_NXT(a_accept_to_reduce, req_take, state_ff == ST_REDUCE)
   // a clear leaves a zero total in both the state and the response
   `KQF_CHECK_NXT(a_clear_zeroes_total, cmd.clear, total_ff == '0 && rsp_total_ff == '0)
   // the total only moves when a merge step completes
   `KQF_CHECK_NXT(a_total_holds, !fire, $stable(total_ff))
   // a response appears only out of the merge step
   `KQF_CHECK_IMP(a_rsp_from_merge, $rose(rsp_valid_ff), $past(state_ff == ST_MERGE))

endmodule

// File: tb/kruskal_quick_find_merger_core_test.sv
// testbench for the quick-find kruskal merger core: directed, back-pressure and random graphs
`timescale 1ns / 1ps
module kruskal_quick_find_merger_core_test;
   import kqf_pkg::*;

   localparam int MAX_V = 1024;
   // the one code the core leaves unused; such a request changes nothing
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_MAX = 10;
   localparam int PHASE_REQUESTS = 120;

   // idling per phase: none, sender only, receiver only, both lightly
   localparam int SEND_IDLE_PCT [4] = '{0, 68, 0, 21};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 68, 21};
   // vertex counts for the random phases, extremes and clamped values among them
   localparam int PHASE_VERTICES [8] = '{6, 1024, 12, 2047, 33, 700, 3, 1};

   typedef struct {
      logic joined;
      logic [TOTAL_W-1:0] total;
   } merge_result_type;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = FUNC_CLEAR;
   logic [NODE_W-1:0] req_node_a = '0;
   logic [NODE_W-1:0] req_node_b = '0;
   logic [WEIGHT_W-1:0] req_weight = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_joined;
   logic [TOTAL_W-1:0] rsp_total_length;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [NV_W-1:0] csr_num_vertices = NV_RESET;

   // predicted state of the core: one label per vertex cell, the tree total, the vertex count
   logic [NODE_W-1:0] label_of [MAX_V];
   logic [TOTAL_W-1:0] tree_total;
   logic [NV_W-1:0] vertex_count;

   // responses owed by the core, oldest first
   merge_result_type awaited_results [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_ask = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int merges_seen = 0;
   int settings_written = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   kruskal_quick_find_merger_core #(
      .MAX_VERTICES(MAX_V)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_node_a(req_node_a),
      .req_node_b(req_node_b),
      .req_weight(req_weight),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_joined(rsp_joined),
      .rsp_total_length(rsp_total_length),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_num_vertices(csr_num_vertices)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // every cell back to its own index, total back to zero
   function automatic void clear_labels();
      for (int i = 0; i < MAX_V; i++) label_of[i] = NODE_W'(i);
      tree_total = '0;
   endfunction

   // vertex count as the core sees it, clamped to the number of cells
   function automatic int unsigned live_vertices();
      return (vertex_count > MAX_V) ? MAX_V : vertex_count;
   endfunction

   // quick-find union: both old labels collapse onto the smaller one across every cell,
   // including cells at or above the live vertex count
   function automatic logic merge_components(input logic [NODE_W-1:0] a, b);
      logic [NODE_W-1:0] la, lb, keep;
      if (a >= live_vertices() || b >= live_vertices()) return 1'b0;
      la = label_of[a];
      lb = label_of[b];
      if (la == lb) return 1'b0;
      keep = (la < lb) ? la : lb;
      for (int i = 0; i < MAX_V; i++)
         if (label_of[i] == la || label_of[i] == lb) label_of[i] = keep;
      return 1'b1;
   endfunction

   function automatic merge_result_type predict_merge(input logic [FUNC_W-1:0] func,
         input logic [NODE_W-1:0] a, b, input logic [WEIGHT_W-1:0] w);
      merge_result_type r;
      logic [TOTAL_W:0] sum;
      r.joined = 1'b0;
      case (func)
         FUNC_CLEAR: clear_labels();
         FUNC_LINK: r.joined = merge_components(a, b);
         FUNC_EDGE: begin
            r.joined = merge_components(a, b);
            // only an edge that joins two components adds its length; total saturates
            if (r.joined) begin
               sum = tree_total + w;
               tree_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
         end
         default: ;
      endcase
      r.total = tree_total;
      return r;
   endfunction

   // ---------------------------------------------------------------- request side

   // offers one request, with random idle cycles ahead of it, and predicts it once taken
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [NODE_W-1:0] a, b,
         input logic [WEIGHT_W-1:0] w);
      merge_result_type r;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      // valid stays high after the accepting edge; the next call lowers or reloads it
      do @(posedge clock); while (req_stall);
      r = predict_merge(func, a, b, w);
      awaited_results.push_back(r);
      if (r.joined) merges_seen++;
      if (func != FUNC_NONE) requests_sent++;
   endtask

   // stop offering and wait for every owed response, plus the pipeline depth
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only with the core drained
   task automatic set_vertex_count(input logic [NV_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_num_vertices <= value;
      do @(posedge clock); while (!csr_ready);
      vertex_count = value;
      settings_written++;
      csr_valid <= 1'b0;
   endtask

   // mostly a vertex in range, now and then any index at all
   function automatic logic [NODE_W-1:0] pick_node();
      if (live_vertices() == 0 || $urandom_range(99) < 8) return NODE_W'($urandom);
      return NODE_W'($urandom_range(0, live_vertices() - 1));
   endfunction

   // ---------------------------------------------------------------- response side

   function automatic void report_mismatch(input string what,
         input logic [TOTAL_W-1:0] want, got);
      if (mismatches < REPORT_MAX)
         $display("tb: %s mismatch at %0t ns: expected %0h, got %0h", what, $time, want, got);
      mismatches++;
   endfunction

   // receiver stall: a long hold when asked, otherwise random at the phase rate
   always @(posedge clock) begin
      int hold_left;
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // each response taken is checked against the oldest prediction
   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (awaited_results.size() == 0) begin
            report_mismatch("unrequested response", '0, rsp_total_length);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_joined !== want.joined)
               report_mismatch("joined", TOTAL_W'(want.joined), TOTAL_W'(rsp_joined));
            if (rsp_total_length !== want.total)
               report_mismatch("total_length", want.total, rsp_total_length);
         end
      end
   end

   // watchdog on cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: no handshake for %0d cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // field extremes, every request code and the corner cases of the label logic
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(FUNC_CLEAR, 10'd1023, 10'd1023, WEIGHT_MAX);
      send_request(FUNC_EDGE, 10'd0, 10'd1023, WEIGHT_MAX);
      send_request(FUNC_EDGE, 10'd1023, 10'd0, 24'd1);        // already joined
      send_request(FUNC_LINK, 10'd5, 10'd6, 24'd0);
      send_request(FUNC_LINK, 10'd6, 10'd5, 24'd0);
      send_request(FUNC_EDGE, 10'd3, 10'd3, 24'd7);           // self loop
      send_request(FUNC_NONE, 10'd1023, 10'd1023, WEIGHT_MAX);
      send_request(FUNC_EDGE, 10'd6, 10'd1023, 24'h100);
      send_request(FUNC_EDGE, 10'd5, 10'd0, 24'h200);
      // no vertices at all: nothing can merge
      set_vertex_count(11'd0);
      send_request(FUNC_EDGE, 10'd0, 10'd1, 24'd5);
      send_request(FUNC_LINK, 10'd0, 10'd0, 24'd0);
      // one vertex: any second endpoint is out of range
      set_vertex_count(11'd1);
      send_request(FUNC_EDGE, 10'd0, 10'd0, 24'd5);
      send_request(FUNC_EDGE, 10'd0, 10'd1, 24'd5);
      send_request(FUNC_LINK, 10'd1, 10'd0, 24'd0);
      // count above the cell array clamps to the full array
      set_vertex_count(11'd2047);
      send_request(FUNC_EDGE, 10'd1023, 10'd2, 24'h300);
      send_request(FUNC_CLEAR, 10'd0, 10'd0, 24'd0);
      set_vertex_count(11'd2);
      send_request(FUNC_EDGE, 10'd0, 10'd1, 24'h10);
      send_request(FUNC_EDGE, 10'd1, 10'd2, 24'h20);
      send_request(FUNC_LINK, 10'd2, 10'd3, 24'd0);
      // relabel reaches cells beyond the live count: 900 follows 4 down to label 0
      send_request(FUNC_CLEAR, 10'd0, 10'd0, 24'd0);
      set_vertex_count(11'd1024);
      send_request(FUNC_LINK, 10'd4, 10'd900, 24'd0);
      set_vertex_count(11'd5);
      send_request(FUNC_LINK, 10'd0, 10'd4, 24'd0);
      set_vertex_count(11'd1024);
      send_request(FUNC_EDGE, 10'd900, 10'd0, 24'h40);
      send_request(FUNC_EDGE, 10'd1023, 10'd900, 24'h800000);
      drain_results();
   endtask

   // receiver holds off for a long stretch while a chain of edges keeps coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(FUNC_CLEAR, 10'd0, 10'd0, 24'd0);
      hold_ask = 60;
      for (int i = 1; i < 24; i++)
         send_request(FUNC_EDGE, NODE_W'(i - 1), NODE_W'(i), WEIGHT_W'(i * 16));
      drain_results();
   endtask

   // whole graphs: clear, a few pre-links, then edges in ascending length, with some noise
   task automatic test_random_graphs(input int quota);
      int stop_at;
      logic [WEIGHT_W-1:0] w, stride;
      logic [NODE_W-1:0] node;
      stop_at = requests_sent + quota;
      while (requests_sent < stop_at) begin
         send_request(FUNC_CLEAR, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
         repeat ($urandom_range(0, 3))
            send_request(FUNC_LINK, pick_node(), pick_node(), WEIGHT_W'($urandom));
         w = WEIGHT_W'($urandom) >> $urandom_range(0, 23);
         repeat ($urandom_range(4, 40)) begin
            if ($urandom_range(99) < 10) begin
               case ($urandom_range(2))
                  0: send_request(FUNC_NONE, NODE_W'($urandom), NODE_W'($urandom),
                        WEIGHT_W'($urandom));
                  1: send_request(FUNC_EDGE, NODE_W'($urandom), NODE_W'($urandom),
                        WEIGHT_W'($urandom));   // out of order, anywhere
                  default: begin
                     node = pick_node();
                     send_request(FUNC_LINK, node, node, WEIGHT_W'($urandom));
                  end
               endcase
            end else begin
               send_request(FUNC_EDGE, pick_node(), pick_node(), w);
               stride = WEIGHT_W'($urandom_range(0, 1 << $urandom_range(0, 18)));
               w = (w > WEIGHT_MAX - stride) ? WEIGHT_MAX : w + stride;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_labels();
      vertex_count = NV_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      for (int p = 0; p < 8; p++) begin
         set_vertex_count(NV_W'(PHASE_VERTICES[p]));
         send_idle_pct = SEND_IDLE_PCT[p % 4];
         recv_stall_pct = RECV_STALL_PCT[p % 4];
         test_random_graphs(PHASE_REQUESTS);
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("tb: %0d responses checked, %0d merges, %0d vertex-count writes, %0d mismatches",
         results_checked, merges_seen, settings_written, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/kqf_pkg.sv
sv/kqf_label_cell.sv
sv/kqf_label_row.sv
sv/kruskal_quick_find_merger_core.sv
tb/kruskal_quick_find_merger_core_test.sv
